// ----- rtl/mvp_pkg.sv -----
// Shared types, codes and constants for the matrix chain block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mvp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W = 64 - FRAC_BITS + 2;

  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_READ    = 2'd1;
  localparam logic [1:0] FN_COMPUTE = 2'd2;

  localparam logic [1:0] MX_WORLD = 2'd0;
  localparam logic [1:0] MX_VIEW  = 2'd1;
  localparam logic [1:0] MX_PROJ  = 2'd2;
  localparam logic [1:0] MX_COMB  = 2'd3;

  localparam logic [1:0] PS_WV    = 2'd0;
  localparam logic [1:0] PS_PROJ  = 2'd1;
  localparam logic [1:0] PS_REMAP = 2'd2;

  localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] FX_TWO = 32'sd2 <<< FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       issue;
    logic [1:0] pass;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic       emit;
    logic [1:0] row;
    logic       emit_from_p;
  } mvp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic remap;
  } mvp_sts_t;

  function automatic logic signed [31:0] ident_elem(input logic [3:0] idx);
    return (idx[3:2] == idx[1:0]) ? FX_ONE : 32'sd0;
  endfunction

  // depth remap: column 2 becomes 2*c2 - c3
  function automatic logic signed [31:0] remap_elem(input logic [3:0] idx);
    logic signed [31:0] v;
    v = ident_elem(idx);
    if (idx == 4'd10) v = FX_TWO;
    if (idx == 4'd14) v = -FX_ONE;
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mvp_ctrl.sv -----
// Sequencer for the matrix chain: accept, multiply passes, row emit.
// Depends on mvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_func,
  output logic                  in_stall,
  input  wire mvp_pkg::mvp_sts_t sts,
  output mvp_pkg::mvp_cmd_t     cmd
);
  import mvp_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic [1:0] row_r, row_nxt;
  logic       start;

  assign start = cmd.accept && (in_func == FN_COMPUTE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    row_nxt   = row_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
          cnt_nxt   = 6'd0;
          pass_nxt  = PS_WV;
        end
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          if (pass_r == PS_REMAP || (pass_r == PS_PROJ && !sts.remap)) begin
            state_nxt = ST_EMIT;
            row_nxt   = 2'd0;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          row_nxt = row_r + 2'd1;
          if (row_r == 2'd3) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = !((state_r == ST_IDLE) && sts.out_free);
    cmd.accept      = in_valid && !in_stall;
    cmd.issue       = (state_r == ST_MUL);
    cmd.pass        = pass_r;
    cmd.i           = cnt_r[5:4];
    cmd.j           = cnt_r[3:2];
    cmd.k           = cnt_r[1:0];
    cmd.emit        = (state_r == ST_EMIT) && sts.out_free;
    cmd.row         = row_r;
    cmd.emit_from_p = sts.remap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 6'd0;
      pass_r  <= PS_WV;
      row_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
      row_r   <= row_nxt;
    end
  end

  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == ST_MUL) else $error("compute not started");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free) else $error("emit into busy output");
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && pass_r == PS_REMAP |-> sts.remap) else $error("remap pass without remap");

endmodule
`default_nettype wire

// ----- rtl/mvp_dp.sv -----
// Datapath: matrix stores, shared multiply-accumulate, output register.
// Depends on mvp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvp_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data,
  input  wire logic [1:0]          in_func,
  input  wire logic [1:0]          in_which_matrix,
  input  wire logic [1:0]          in_row_sel,
  input  wire logic [1:0]          in_col_sel,
  input  wire logic signed [31:0]  in_elem_value,
  input  wire mvp_pkg::mvp_cmd_t   cmd,
  output mvp_pkg::mvp_sts_t        sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_row_index,
  output logic signed [31:0]       out_col0_value,
  output logic signed [31:0]       out_col1_value,
  output logic signed [31:0]       out_col2_value,
  output logic signed [31:0]       out_col3_value,
  output logic                     out_last
);
  import mvp_pkg::*;

  logic signed [31:0] world_r [16];
  logic signed [31:0] view_r  [16];
  logic signed [31:0] proj_r  [16];
  logic signed [31:0] comb_r  [16];
  logic signed [31:0] part_r  [16];

  logic remap_r;
  logic [3:0] pos;
  logic wr_item, rd_item;
  logic [3:0] a_idx, b_idx;
  logic signed [31:0] a_val, b_val, rd_val;

  logic signed [63:0] prod_r;
  logic        tv_r, tfirst_r, tlast_r;
  logic [1:0]  tpass_r;
  logic [3:0]  tdst_r;
  logic signed [63:0] prod_sh;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [31:0] sat_val;
  logic wb_p, wb_c;

  logic        out_valid_r;
  logic [1:0]  out_row_r;
  logic signed [31:0] out_c_r [4];
  logic        out_last_r;

  assign pos     = {in_row_sel, in_col_sel};
  assign wr_item = cmd.accept && (in_func == FN_WRITE);
  assign rd_item = cmd.accept && (in_func == FN_READ);
  assign a_idx   = {cmd.i, cmd.k};
  assign b_idx   = {cmd.k, cmd.j};

  always_comb begin
    case (cmd.pass)
      PS_WV:    begin a_val = world_r[a_idx]; b_val = view_r[b_idx]; end
      PS_PROJ:  begin a_val = part_r[a_idx];  b_val = proj_r[b_idx]; end
      default:  begin a_val = comb_r[a_idx];  b_val = remap_elem(b_idx); end
    endcase
    case (in_which_matrix)
      MX_WORLD: rd_val = world_r[pos];
      MX_VIEW:  rd_val = view_r[pos];
      MX_PROJ:  rd_val = proj_r[pos];
      default:  rd_val = comb_r[pos];
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r   <= 64'(a_val) * 64'(b_val);
    tfirst_r <= (cmd.k == 2'd0);
    tlast_r  <= (cmd.k == 2'd3);
    tpass_r  <= cmd.pass;
    tdst_r   <= {cmd.i, cmd.j};
    if (tv_r) acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tv_r <= 1'b0;
    else tv_r <= cmd.issue;
  end

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign acc_nxt = (tfirst_r ? '0 : acc_r) + prod_sh[ACC_W-1:0];

  always_comb begin
    if (acc_nxt > ACC_W'(64'sh7FFFFFFF)) sat_val = 32'sh7FFFFFFF;
    else if (acc_nxt < -ACC_W'(64'sh80000000)) sat_val = 32'sh80000000;
    else sat_val = acc_nxt[31:0];
  end

  assign wb_p = tv_r && tlast_r && (tpass_r != PS_PROJ);
  assign wb_c = tv_r && tlast_r && (tpass_r == PS_PROJ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_r <= 1'b0;
      for (int e = 0; e < 16; e++) begin
        world_r[e] <= ident_elem(4'(e));
        view_r[e]  <= ident_elem(4'(e));
        proj_r[e]  <= ident_elem(4'(e));
        comb_r[e]  <= ident_elem(4'(e));
      end
    end else begin
      if (cfg_wr_en) remap_r <= cfg_wr_data;
      if (wr_item && in_which_matrix == MX_WORLD) world_r[pos] <= in_elem_value;
      if (wr_item && in_which_matrix == MX_VIEW)  view_r[pos]  <= in_elem_value;
      if (wr_item && in_which_matrix == MX_PROJ)  proj_r[pos]  <= in_elem_value;
      if (wr_item && in_which_matrix == MX_COMB)  comb_r[pos]  <= in_elem_value;
      if (wb_c) comb_r[tdst_r] <= sat_val;
      if (cmd.emit && cmd.emit_from_p) begin
        for (int c = 0; c < 4; c++) comb_r[{cmd.row, 2'(c)}] <= part_r[{cmd.row, 2'(c)}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_p) part_r[tdst_r] <= sat_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (rd_item || cmd.emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rd_item) begin
      out_row_r  <= 2'd0;
      out_c_r[0] <= rd_val;
      out_c_r[1] <= 32'sd0;
      out_c_r[2] <= 32'sd0;
      out_c_r[3] <= 32'sd0;
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_row_r  <= cmd.row;
      for (int c = 0; c < 4; c++) begin
        out_c_r[c] <= cmd.emit_from_p ? part_r[{cmd.row, 2'(c)}] : comb_r[{cmd.row, 2'(c)}];
      end
      out_last_r <= (cmd.row == 2'd3);
    end
  end

  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.remap      = remap_r;
  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_col0_value = out_c_r[0];
  assign out_col1_value = out_c_r[1];
  assign out_col2_value = out_c_r[2];
  assign out_col3_value = out_c_r[3];
  assign out_last       = out_last_r;

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_row_r != 2'd3) else $error("row 3 without last");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    wb_c && cmd.emit |-> tdst_r[3:2] != cmd.row) else $error("writeback into emitted row");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_item || cmd.emit) |-> sts.out_free) else $error("output overwritten");

endmodule
`default_nettype wire

// ----- rtl/mvp_matrix_chain_top.sv -----
// Top level of the model-view-projection matrix chain.
// Depends on mvp_pkg, mvp_ctrl, mvp_dp.
//
//  channel | signals                                   | role
//  in      | in_valid in_stall in_func .. elem_value    | write/read/compute request
//  out     | out_valid out_stall out_row_index .. last  | result rows
//  cfg     | cfg_wr_en cfg_wr_data                      | depth remap enable
//
// Write: updates the addressed element. Read: loads the element into the output register.
// Compute: multiply passes on one shared multiply-accumulate (2 passes, 3 with remap),
// then 4 result rows are emitted, each one waiting while the output is stalled.
// Synchronous active-low reset restores identity matrices and clears remap.
// Output stall holds the row and blocks new requests until it drains.
`timescale 1ns / 1ps
`default_nettype none
module mvp_matrix_chain_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic [1:0]         in_which_matrix,
  input  wire logic [1:0]         in_row_sel,
  input  wire logic [1:0]         in_col_sel,
  input  wire logic signed [31:0] in_elem_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_row_index,
  output logic signed [31:0]      out_col0_value,
  output logic signed [31:0]      out_col1_value,
  output logic signed [31:0]      out_col2_value,
  output logic signed [31:0]      out_col3_value,
  output logic                    out_last
);
  import mvp_pkg::*;

  mvp_cmd_t cmd;
  mvp_sts_t sts;

  mvp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mvp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_func         (in_func),
    .in_which_matrix (in_which_matrix),
    .in_row_sel      (in_row_sel),
    .in_col_sel      (in_col_sel),
    .in_elem_value   (in_elem_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_col0_value  (out_col0_value),
    .out_col1_value  (out_col1_value),
    .out_col2_value  (out_col2_value),
    .out_col3_value  (out_col3_value),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// ----- tb/mvp_matrix_chain_checker.sv -----
// Checker for the matrix chain block: watches the request and result channels,
// predicts result rows from its own copy of the matrices. Depends on mvp_pkg.
`timescale 1ns / 1ps
module mvp_matrix_chain_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [1:0]         in_which_matrix,
  input  logic [1:0]         in_row_sel,
  input  logic [1:0]         in_col_sel,
  input  logic signed [31:0] in_elem_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_row_index,
  input  logic signed [31:0] out_col0_value,
  input  logic signed [31:0] out_col1_value,
  input  logic signed [31:0] out_col2_value,
  input  logic signed [31:0] out_col3_value,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending_rows,
  output int                 rows_seen
);
  import mvp_pkg::*;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic               last;
  } row_t;

  typedef logic signed [31:0] mat_t [16];

  mat_t world_m, view_m, proj_m, comb_m;
  logic remap_on;
  row_t expected_rows[$];

  assign pending_rows = expected_rows.size();

  function automatic mat_t identity_mat();
    mat_t m;
    for (int n = 0; n < 16; n++) m[n] = (n % 5 == 0) ? FX_ONE : 32'sd0;
    return m;
  endfunction

  function automatic mat_t fx_matmul(mat_t a, mat_t b);
    mat_t r;
    logic signed [63:0] prod;
    logic signed [63:0] acc;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = 64'(a[i*4+k]) * 64'(b[k*4+j]);
          acc += prod >>> FRAC_BITS;
        end
        if (acc > 64'sd2147483647) r[i*4+j] = 32'sh7fffffff;
        else if (acc < -64'sd2147483648) r[i*4+j] = 32'sh80000000;
        else r[i*4+j] = acc[31:0];
      end
    end
    return r;
  endfunction

  task automatic predict_request();
    logic [3:0] pos;
    mat_t remap_m;
    row_t r;
    pos = {in_row_sel, in_col_sel};
    case (in_func)
      FN_WRITE: begin
        case (in_which_matrix)
          MX_WORLD: world_m[pos] = in_elem_value;
          MX_VIEW:  view_m[pos] = in_elem_value;
          MX_PROJ:  proj_m[pos] = in_elem_value;
          default:  comb_m[pos] = in_elem_value;
        endcase
      end
      FN_READ: begin
        r = '0;
        r.last = 1'b1;
        case (in_which_matrix)
          MX_WORLD: r.c0 = world_m[pos];
          MX_VIEW:  r.c0 = view_m[pos];
          MX_PROJ:  r.c0 = proj_m[pos];
          default:  r.c0 = comb_m[pos];
        endcase
        expected_rows.push_back(r);
      end
      FN_COMPUTE: begin
        comb_m = fx_matmul(fx_matmul(world_m, view_m), proj_m);
        if (remap_on) begin
          remap_m = identity_mat();
          remap_m[10] = FX_TWO;
          remap_m[14] = -FX_ONE;
          comb_m = fx_matmul(comb_m, remap_m);
        end
        for (int i = 0; i < 4; i++) begin
          r.row_index = 2'(i);
          r.c0 = comb_m[i*4];
          r.c1 = comb_m[i*4+1];
          r.c2 = comb_m[i*4+2];
          r.c3 = comb_m[i*4+3];
          r.last = (i == 3);
          expected_rows.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_row();
    row_t e;
    if (expected_rows.size() == 0) begin
      $error("unexpected result row %0d", out_row_index);
      fail_count++;
      return;
    end
    e = expected_rows.pop_front();
    check_field("row_index", 32'(e.row_index), 32'(out_row_index));
    check_field("col0_value", e.c0, out_col0_value);
    check_field("col1_value", e.c1, out_col1_value);
    check_field("col2_value", e.c2, out_col2_value);
    check_field("col3_value", e.c3, out_col3_value);
    check_field("last", 32'(e.last), 32'(out_last));
  endtask

  initial begin
    fail_count = 0;
    rows_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      world_m = identity_mat();
      view_m = identity_mat();
      proj_m = identity_mat();
      comb_m = identity_mat();
      remap_on = 1'b0;
      expected_rows.delete();
    end else begin
      if (cfg_wr_en) remap_on = cfg_wr_data;
      if (out_valid && !out_stall) begin
        check_row();
        rows_seen++;
      end
      if (in_valid && !in_stall) predict_request();
    end
  end

endmodule

// ----- tb/mvp_matrix_chain_top_tb.sv -----
// Testbench top for the matrix chain block: drives write, read and compute
// requests and the remap register. Depends on mvp_pkg, the block, the checker.
`timescale 1ns / 1ps
module mvp_matrix_chain_top_tb;
  import mvp_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FN_WRITE;
  logic [1:0]         in_which_matrix = MX_WORLD;
  logic [1:0]         in_row_sel = '0;
  logic [1:0]         in_col_sel = '0;
  logic signed [31:0] in_elem_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_row_index;
  logic signed [31:0] out_col0_value, out_col1_value, out_col2_value, out_col3_value;
  logic               out_last;
  int                 fail_count, pending_rows, rows_seen;
  int                 sent = 0;
  bit                 quiet = 1'b0;
  bit                 hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mvp_matrix_chain_top DUT (.*);

  mvp_matrix_chain_checker checker_i (.*);

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_request(logic [1:0] f, logic [1:0] wm, logic [1:0] r, logic [1:0] c,
                              logic signed [31:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_which_matrix <= wm;
    in_row_sel <= r;
    in_col_sel <= c;
    in_elem_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic set_remap(logic v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
    endcase
  endfunction

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_request(FN_READ, MX_WORLD, 2'd0, 2'd0, 0);
    send_request(FN_READ, MX_COMB, 2'd3, 2'd3, 0);
    send_request(FN_COMPUTE, MX_COMB, 2'd3, 2'd3, 32'sh7fffffff);
    send_request(FN_WRITE, MX_WORLD, 2'd0, 2'd0, 32'sh7fffffff);
    send_request(FN_WRITE, MX_VIEW, 2'd0, 2'd0, 32'sh7fffffff);
    send_request(FN_WRITE, MX_PROJ, 2'd3, 2'd3, 32'sh80000000);
    send_request(FN_WRITE, MX_WORLD, 2'd1, 2'd2, -32'sd65536);
    send_request(FN_READ, MX_PROJ, 2'd3, 2'd3, 0);
    send_request(FN_COMPUTE, MX_WORLD, 2'd0, 2'd0, 0);
    send_request(FN_WRITE, MX_COMB, 2'd2, 2'd1, 32'sh12345678);
    send_request(FN_READ, MX_COMB, 2'd2, 2'd1, 0);
    send_request(2'd3, MX_VIEW, 2'd1, 2'd1, 32'sh5a5a5a5a);
    set_remap(1'b1);
    send_request(FN_COMPUTE, MX_PROJ, 2'd0, 2'd0, 0);
    send_request(FN_WRITE, MX_VIEW, 2'd1, 2'd1, 32'sh80000000);
    send_request(FN_COMPUTE, MX_VIEW, 2'd1, 2'd1, 0);
    send_request(FN_READ, MX_VIEW, 2'd1, 2'd1, 0);

    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    for (int n = 0; n < 6; n++) send_request(FN_READ, 2'(n), 2'(n), 2'(n + 1), 0);
    set_remap(1'b0);

    // random
    for (int n = 0; n < 100; n++) begin
      if (n == 50) set_remap(1'b1);
      if (n == 85) begin
        set_remap(1'b0);
        quiet = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 11)
        send_request(FN_WRITE, 2'($urandom), 2'($urandom), 2'($urandom), rand_elem());
      else if (pick < 16)
        send_request(FN_READ, 2'($urandom), 2'($urandom), 2'($urandom), $urandom);
      else if (pick < 19)
        send_request(FN_COMPUTE, 2'($urandom), 2'($urandom), 2'($urandom), $urandom);
      else
        send_request(2'd3, 2'($urandom), 2'($urandom), 2'($urandom), $urandom);
    end

    drain();
    $display("Covered %0d requests and %0d result rows over writes, reads, computes,",
             sent, rows_seen);
    $display("ignored codes, both remap settings and a long output hold-off.");
    if (fail_count == 0 && pending_rows == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mvp_pkg.sv
rtl/mvp_ctrl.sv
rtl/mvp_dp.sv
rtl/mvp_matrix_chain_top.sv
tb/mvp_matrix_chain_checker.sv
tb/mvp_matrix_chain_top_tb.sv
